>>> rtl/assert_macros.svh
// Assertion macros used by the checker file seg_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SEG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("segment_intersection assertion failed");

// Implication from a condition to a property in the next cycle.
`define SEG_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("segment_intersection assertion failed");

`endif

>>> rtl/seg_pkg.sv
// Package: widths and the divider stage word for the segment intersection pipeline.
package seg_pkg;
  localparam int CW = 32;          // coordinate width
  localparam int DW = CW + 1;      // difference width
  localparam int PW = 2 * DW;      // product width
  localparam int XW = PW + 1;      // cross product width
  localparam int RW = XW + 1;      // divider remainder width
  localparam int TW = 32;          // parameter width, Q2.30
  localparam int QW = TW - 1;      // quotient magnitude bits
  localparam int FB = 30;          // parameter fraction bits
  localparam int SW = CW + 5;      // point sum width

  localparam logic [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

  typedef struct packed {
    logic [XW-1:0]          md;
    logic [RW-1:0]          ra;
    logic [RW-1:0]          rb;
    logic [QW-1:0]          qa;
    logic [QW-1:0]          qb;
    logic                   nega;
    logic                   negb;
    logic                   sata;
    logic                   satb;
    logic                   hit;
    logic                   par;
    logic signed [DW-1:0]   vax;
    logic signed [DW-1:0]   vay;
    logic signed [CW-1:0]   a0x;
    logic signed [CW-1:0]   a0y;
  } div_t;
endpackage

>>> rtl/seg_front.sv
// Front stages: differences, cross products, magnitudes and range checks.
module seg_front import seg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] a_start_x,
  input  logic signed [CW-1:0] a_start_y,
  input  logic signed [CW-1:0] a_end_x,
  input  logic signed [CW-1:0] a_end_y,
  input  logic signed [CW-1:0] b_start_x,
  input  logic signed [CW-1:0] b_start_y,
  input  logic signed [CW-1:0] b_end_x,
  input  logic signed [CW-1:0] b_end_y,
  output logic                 dv,
  output div_t                 dw
);
  logic [4:0] v;

  logic signed [DW-1:0] vax1, vay1, vbx1, vby1, vabx1, vaby1;
  logic signed [CW-1:0] a0x1, a0y1, a0x2, a0y2, a0x3, a0y3, a0x4, a0y4;
  logic signed [DW-1:0] vax2, vay2, vax3, vay3, vax4, vay4;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [XW-1:0] det, na, nb;
  logic [XW-1:0]        md, mna, mnb;
  logic                 nega, negb, par, sda, sdb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vax1  <= DW'(a_end_x) - DW'(a_start_x);
      vay1  <= DW'(a_end_y) - DW'(a_start_y);
      vbx1  <= DW'(b_end_x) - DW'(b_start_x);
      vby1  <= DW'(b_end_y) - DW'(b_start_y);
      vabx1 <= DW'(b_start_x) - DW'(a_start_x);
      vaby1 <= DW'(b_start_y) - DW'(a_start_y);
      a0x1  <= a_start_x;
      a0y1  <= a_start_y;

      p0   <= vax1 * vby1;
      p1   <= vay1 * vbx1;
      p2   <= vabx1 * vby1;
      p3   <= vaby1 * vbx1;
      p4   <= vabx1 * vay1;
      p5   <= vaby1 * vax1;
      vax2 <= vax1;
      vay2 <= vay1;
      a0x2 <= a0x1;
      a0y2 <= a0y1;

      det  <= XW'(p0) - XW'(p1);
      na   <= XW'(p2) - XW'(p3);
      nb   <= XW'(p4) - XW'(p5);
      vax3 <= vax2;
      vay3 <= vay2;
      a0x3 <= a0x2;
      a0y3 <= a0y2;

      md   <= det[XW-1] ? XW'(-det) : XW'(det);
      mna  <= na[XW-1] ? XW'(-na) : XW'(na);
      mnb  <= nb[XW-1] ? XW'(-nb) : XW'(nb);
      sda  <= na[XW-1] != det[XW-1];
      sdb  <= nb[XW-1] != det[XW-1];
      nega <= (na[XW-1] != det[XW-1]) && (na != '0);
      negb <= (nb[XW-1] != det[XW-1]) && (nb != '0);
      par  <= det == '0;
      vax4 <= vax3;
      vay4 <= vay3;
      a0x4 <= a0x3;
      a0y4 <= a0y3;

      dw.md   <= md;
      dw.ra   <= RW'(mna);
      dw.rb   <= RW'(mnb);
      dw.qa   <= '0;
      dw.qb   <= '0;
      dw.nega <= nega;
      dw.negb <= negb;
      dw.sata <= RW'(mna) >= {md, 1'b0};
      dw.satb <= RW'(mnb) >= {md, 1'b0};
      dw.hit  <= ((mna == '0) || (!sda && mna <= md)) &&
                 ((mnb == '0) || (!sdb && mnb <= md));
      dw.par  <= par;
      dw.vax  <= vax4;
      dw.vay  <= vay4;
      dw.a0x  <= a0x4;
      dw.a0y  <= a0y4;
    end
  end

  assign dv = v[4];
endmodule

>>> rtl/seg_div.sv
// Restoring divider, one quotient bit per stage for both parameters.
module seg_div import seg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic iv,
  input  div_t iw,
  output logic ov,
  output div_t ow
);
  logic [QW-1:0] v;
  div_t          st [QW];
  div_t          nx [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    div_t          src;
    logic [RW-1:0] sa, sb, dm;
    if (i == 0) begin : g_first
      assign src = iw;
      assign sa  = iw.ra;
      assign sb  = iw.rb;
    end else begin : g_rest
      assign src = st[i-1];
      assign sa  = {st[i-1].ra[RW-2:0], 1'b0};
      assign sb  = {st[i-1].rb[RW-2:0], 1'b0};
    end
    assign dm = {1'b0, src.md};
    always_comb begin
      nx[i]    = src;
      nx[i].ra = (sa >= dm) ? sa - dm : sa;
      nx[i].rb = (sb >= dm) ? sb - dm : sb;
      nx[i].qa = {src.qa[QW-2:0], sa >= dm};
      nx[i].qb = {src.qb[QW-2:0], sb >= dm};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[i] <= nx[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[QW-2:0], iv};
    end
  end

  assign ov = v[QW-1];
  assign ow = st[QW-1];
endmodule

>>> rtl/seg_point.sv
// Back stages: signed saturated parameters, point products, output register.
module seg_point import seg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 iv,
  input  div_t                 iw,
  output logic                 ov,
  output logic                 hit,
  output logic                 parallel,
  output logic signed [TW-1:0] t_along_a,
  output logic signed [TW-1:0] t_along_b,
  output logic signed [CW-1:0] cross_x,
  output logic signed [CW-1:0] cross_y
);
  logic [1:0]             v;
  logic signed [TW-1:0]   ta, tb, ta2, tb2;
  logic                   hit1, par1, hit2, par2;
  logic signed [DW-1:0]   vax1, vay1;
  logic signed [CW-1:0]   a0x1, a0y1, a0x2, a0y2;
  logic signed [DW+TW-1:0] px, py;
  logic signed [SW-1:0]   sx, sy;
  logic signed [SW-1:0]   cmax, cmin;

  function automatic logic [TW-1:0] tval(logic sat, logic neg, logic [QW-1:0] q);
    logic [TW-1:0] m;
    m = {1'b0, q};
    if (sat) begin
      return neg ? T_MIN : T_MAX;
    end
    return neg ? TW'(-m) : m;
  endfunction

  assign cmax = SW'({1'b0, {(CW-1){1'b1}}});
  assign cmin = -cmax - SW'(1);
  assign sx   = SW'(a0x2) + SW'(px >>> FB);
  assign sy   = SW'(a0y2) + SW'(py >>> FB);

  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      ov <= 1'b0;
    end else if (adv) begin
      v  <= {v[0], iv};
      ov <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta   <= iw.par ? '0 : tval(iw.sata, iw.nega, iw.qa);
      tb   <= iw.par ? '0 : tval(iw.satb, iw.negb, iw.qb);
      hit1 <= iw.hit && !iw.par;
      par1 <= iw.par;
      vax1 <= iw.vax;
      vay1 <= iw.vay;
      a0x1 <= iw.a0x;
      a0y1 <= iw.a0y;

      px   <= vax1 * ta;
      py   <= vay1 * ta;
      ta2  <= ta;
      tb2  <= tb;
      hit2 <= hit1;
      par2 <= par1;
      a0x2 <= a0x1;
      a0y2 <= a0y1;

      hit       <= hit2;
      parallel  <= par2;
      t_along_a <= ta2;
      t_along_b <= tb2;
      if (par2) begin
        cross_x <= '0;
        cross_y <= '0;
      end else begin
        cross_x <= (sx > cmax) ? CW'(cmax) : ((sx < cmin) ? CW'(cmin) : CW'(sx));
        cross_y <= (sy > cmax) ? CW'(cmax) : ((sy < cmin) ? CW'(cmin) : CW'(sy));
      end
    end
  end
endmodule

>>> rtl/segment_intersection.sv
// Top level: pipelined 2D segment intersection in fixed point.
// Takes one segment pair per cycle while the output is not stalled and returns
// one result word per pair, in order: five stages form the differences, cross
// products, magnitudes and range checks, 31 stages of the restoring divider give
// one quotient bit each for both parameters, and three stages form the
// parameters, the point products and the saturated output register. A stall at
// the output freezes the whole pipeline; in_ready is high whenever the output
// register is empty or being taken.
module segment_intersection import seg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] a_start_x,
  input  logic signed [CW-1:0] a_start_y,
  input  logic signed [CW-1:0] a_end_x,
  input  logic signed [CW-1:0] a_end_y,
  input  logic signed [CW-1:0] b_start_x,
  input  logic signed [CW-1:0] b_start_y,
  input  logic signed [CW-1:0] b_end_x,
  input  logic signed [CW-1:0] b_end_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic                 parallel,
  output logic signed [TW-1:0] t_along_a,
  output logic signed [TW-1:0] t_along_b,
  output logic signed [CW-1:0] cross_x,
  output logic signed [CW-1:0] cross_y
);
  logic adv, fv, qv;
  div_t fw, qw;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  seg_front u_front (
    .clk, .rst, .adv,
    .in_vld(in_valid),
    .a_start_x, .a_start_y, .a_end_x, .a_end_y,
    .b_start_x, .b_start_y, .b_end_x, .b_end_y,
    .dv(fv), .dw(fw)
  );

  seg_div u_div (
    .clk, .rst, .adv,
    .iv(fv), .iw(fw), .ov(qv), .ow(qw)
  );

  seg_point u_point (
    .clk, .rst, .adv,
    .iv(qv), .iw(qw), .ov(out_valid),
    .hit, .parallel, .t_along_a, .t_along_b, .cross_x, .cross_y
  );
endmodule

>>> rtl/seg_checker.sv
// Port checker for segment_intersection, bound to the top level.
`include "assert_macros.svh"

module seg_checker import seg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic                 parallel,
  input logic signed [TW-1:0] t_along_a,
  input logic signed [TW-1:0] t_along_b,
  input logic signed [CW-1:0] cross_x,
  input logic signed [CW-1:0] cross_y
);
  logic par_zero, ta_unit, tb_unit;

  assign par_zero = !hit && t_along_a == '0 && t_along_b == '0 &&
                    cross_x == '0 && cross_y == '0;
  assign ta_unit  = !t_along_a[TW-1] && t_along_a <= (TW'(1) <<< FB);
  assign tb_unit  = !t_along_b[TW-1] && t_along_b <= (TW'(1) <<< FB);

  `SEG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cross_x))
  `SEG_ASSERT(a_in_ready, in_ready == (!out_valid || out_ready))
  `SEG_ASSERT(a_par_zero, !(out_valid && parallel) || par_zero)
  `SEG_ASSERT(a_hit_range, !(out_valid && hit) || (ta_unit && tb_unit))
endmodule

bind segment_intersection seg_checker u_seg_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .hit(hit), .parallel(parallel),
  .t_along_a(t_along_a), .t_along_b(t_along_b),
  .cross_x(cross_x), .cross_y(cross_y)
);
